>>> hdl/transfer_function_key_interpolator_assert.svh
// assertion macros for the transfer function key interpolator
`ifndef TRANSFER_FUNCTION_KEY_INTERPOLATOR_ASSERT_SVH
`define TRANSFER_FUNCTION_KEY_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define TFKI_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tfki assertion failed");

// next-cycle implication
`define TFKI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tfki assertion failed");

`endif

>>> hdl/tfki_pkg.sv
// types, constants and helpers shared by the transfer function key interpolator
`default_nettype none
package tfki_pkg;

   typedef struct packed {
      logic        mode;
      logic [2:0]  key_slot;
      logic [16:0] key_level;
      logic [7:0]  left_red;
      logic [7:0]  left_green;
      logic [7:0]  left_blue;
      logic [7:0]  left_alpha;
      logic [7:0]  right_red;
      logic [7:0]  right_green;
      logic [7:0]  right_blue;
      logic [7:0]  right_alpha;
      logic [11:0] entry_index;
   } req_item_type;

   typedef struct packed {
      logic [11:0] entry_echo;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
   } rsp_item_type;

   typedef struct packed {
      logic [3:0]  key_count;
      logic [12:0] table_size;
      logic [16:0] left_threshold;
      logic [16:0] right_threshold;
   } csr_type;

   localparam logic [1:0] CSR_KEY_COUNT       = 2'd0;
   localparam logic [1:0] CSR_TABLE_SIZE      = 2'd1;
   localparam logic [1:0] CSR_LEFT_THRESHOLD  = 2'd2;
   localparam logic [1:0] CSR_RIGHT_THRESHOLD = 2'd3;

   localparam logic [3:0]  KEY_COUNT_RESET       = 4'd1;
   localparam logic [12:0] TABLE_SIZE_RESET      = 13'd256;
   localparam logic [16:0] LEFT_THRESHOLD_RESET  = 17'd0;
   localparam logic [16:0] RIGHT_THRESHOLD_RESET = 17'd65536;

   localparam logic MODE_KEY    = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   // queue between front and back
   localparam int Q_DEPTH = 2;

   typedef struct packed {
      logic        is_key;
      logic [2:0]  slot;
      logic [16:0] level;
      logic [31:0] left_color;
      logic [31:0] right_color;
      logic [11:0] index;
      logic        in_band;
   } qentry_type;

   typedef struct packed {
      logic       stage_valid;
      logic       q_full;
      logic [1:0] q_count;
   } front_status_type;

   typedef struct packed {
      logic active;
      logic pop;
   } back_status_type;

   localparam int DIVIDEND_W = 33;
   localparam int DIVISOR_W  = 17;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [12:0] sat_size(input logic [12:0] ts, input int unsigned max_e);
      logic [12:0] r;
      if (32'(ts) > max_e) r = 13'(max_e);
      else r = ts;
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/tfki_front.sv
// front part: input stage, band classification and item queue
`default_nettype none
module tfki_front
   import tfki_pkg::*;
#(
   parameter int MAX_ENTRIES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire req_item_type     item,
   input  wire csr_type          csr,
   input  wire logic             pop,
   output logic                  busy,
   output qentry_type            head,
   output logic                  head_valid,
   output front_status_type      status
);
   localparam int QPTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

   req_item_type stage_ff;
   logic         stage_valid_ff, stage_valid_in;
   logic [13:0]  front_lim_ff, back_lim_ff;
   logic [12:0]  size_ff;
   qentry_type   qmem_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]   count_ff, count_in;

   logic [12:0] size;
   logic [29:0] lt_prod, rt_prod;
   logic [29:0] lt_round, rt_round;
   logic        q_full, push, accept, in_band;
   qentry_type  entry;

   assign size     = sat_size(csr.table_size, MAX_ENTRIES);
   assign lt_prod  = 30'(csr.left_threshold) * 30'(size);
   assign rt_prod  = 30'(csr.right_threshold) * 30'(size);
   assign lt_round = lt_prod + 30'd32768;
   assign rt_round = rt_prod + 30'd32768;

   assign q_full = (count_ff == 2'(Q_DEPTH));
   assign push   = stage_valid_ff && !q_full;
   assign busy   = stage_valid_ff && q_full;
   assign accept = start && !busy;

   assign in_band = ({2'b0, stage_ff.entry_index} >= front_lim_ff)
                 && ({2'b0, stage_ff.entry_index} < back_lim_ff)
                 && ({1'b0, stage_ff.entry_index} < size_ff);

   always_comb begin
      entry.is_key      = (stage_ff.mode == MODE_KEY);
      entry.slot        = stage_ff.key_slot;
      entry.level       = stage_ff.key_level;
      entry.left_color  = {stage_ff.left_alpha, stage_ff.left_blue,
                           stage_ff.left_green, stage_ff.left_red};
      entry.right_color = {stage_ff.right_alpha, stage_ff.right_blue,
                           stage_ff.right_green, stage_ff.right_red};
      entry.index       = stage_ff.entry_index;
      entry.in_band     = in_band;
   end

   always_comb begin
      stage_valid_in = accept || busy;
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      front_lim_ff <= lt_round[29:16];
      back_lim_ff  <= rt_round[29:16];
      size_ff      <= size;
      if (accept) begin
         stage_ff <= item;
      end
      if (push) begin
         qmem_ff[wptr_ff] <= entry;
      end
      if (reset) begin
         stage_valid_ff <= 1'b0;
         wptr_ff        <= '0;
         rptr_ff        <= '0;
         count_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         wptr_ff        <= wptr_in;
         rptr_ff        <= rptr_in;
         count_ff       <= count_in;
      end
   end

   assign head       = qmem_ff[rptr_ff];
   assign head_valid = (count_ff != 2'd0);

   assign status.stage_valid = stage_valid_ff;
   assign status.q_full      = q_full;
   assign status.q_count     = count_ff;
endmodule
`default_nettype wire

>>> hdl/tfki_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module tfki_div
   import tfki_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;

   logic [DIVISOR_W:0] trial, diff;
   logic               fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIVIDEND_W);
         quo_in   = req.dividend;
         rem_in   = '0;
         div_in   = req.divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

>>> hdl/tfki_back.sv
// back part: key store, key scan and color interpolation sequencer
`default_nettype none
module tfki_back
   import tfki_pkg::*;
#(
   parameter int MAX_KEYS    = 8,
   parameter int MAX_ENTRIES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire csr_type     csr,
   input  wire qentry_type  head,
   input  wire logic        head_valid,
   input  wire div_rsp_type div_rsp,
   output div_req_type      div_req,
   output back_status_type  status,
   output logic             rsp_valid,
   output rsp_item_type     rsp_item
);
   localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int NW = $clog2(MAX_KEYS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_V,
      ST_READ,
      ST_CMP,
      ST_DIV_F,
      ST_MIX
   } state_type;

   state_type    state_ff, state_in;
   logic [11:0]  x_ff, x_in;
   logic [16:0]  v_ff, v_in;
   logic [KW-1:0] k_ff, k_in;
   logic [16:0]  prev_int_ff, prev_int_in;
   logic [31:0]  prev_rc_ff, prev_rc_in;
   logic [31:0]  b_ff, b_in;
   logic [16:0]  f_ff, f_in;
   logic [1:0]   ch_ff, ch_in;
   logic [31:0]  acc_ff, acc_in;
   div_req_type  div_req_ff, div_req_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic [16:0] int_mem [MAX_KEYS];
   logic [31:0] lc_mem [MAX_KEYS];
   logic [31:0] rc_mem [MAX_KEYS];
   logic [16:0] rd_int_ff;
   logic [31:0] rd_lc_ff, rd_rc_ff;

   logic [12:0]   size;
   logic [NW-1:0] n_eff;
   logic          pop, wr_en;
   logic [KW-1:0] wr_addr;
   logic [7:0]    ca, cb, chan;
   logic [25:0]   mix;
   logic [31:0]   color;
   logic          finish;

   assign size = sat_size(csr.table_size, MAX_ENTRIES);

   always_comb begin
      if (csr.key_count == 4'd0) n_eff = NW'(1);
      else if (32'(csr.key_count) > MAX_KEYS) n_eff = NW'(MAX_KEYS);
      else n_eff = NW'(csr.key_count);
   end

   assign pop     = (state_ff == ST_IDLE) && head_valid;
   assign wr_en   = pop && head.is_key && (32'(head.slot) < MAX_KEYS);
   assign wr_addr = KW'(head.slot);

   assign ca   = prev_rc_ff[8*ch_ff +: 8];
   assign cb   = b_ff[8*ch_ff +: 8];
   assign mix  = 26'(ca) * 26'(17'h10000 - f_ff) + 26'(cb) * 26'(f_ff) + 26'd32768;
   assign chan = mix[23:16];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         int_mem[wr_addr] <= head.level;
         lc_mem[wr_addr]  <= head.left_color;
         rc_mem[wr_addr]  <= head.right_color;
      end
      rd_int_ff <= int_mem[k_ff];
      rd_lc_ff  <= lc_mem[k_ff];
      rd_rc_ff  <= rc_mem[k_ff];
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      prev_int_in  = prev_int_ff;
      prev_rc_in   = prev_rc_ff;
      b_in         = b_ff;
      f_in         = f_ff;
      ch_in        = ch_ff;
      acc_in       = acc_ff;
      div_req_in   = div_req_ff;
      div_req_in.start = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      finish       = 1'b0;
      color        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (pop && !head.is_key) begin
               x_in = head.index;
               if (!head.in_band) begin
                  finish = 1'b1;
               end else if (size == 13'd1) begin
                  v_in     = '0;
                  k_in     = '0;
                  state_in = ST_READ;
               end else begin
                  div_req_in.start    = 1'b1;
                  div_req_in.dividend = {5'b0, head.index, 16'b0};
                  div_req_in.divisor  = {4'b0, size - 13'd1};
                  state_in            = ST_DIV_V;
               end
            end
         end
         ST_DIV_V: begin
            if (div_rsp.done) begin
               v_in     = div_rsp.quotient[16:0];
               k_in     = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (v_ff > rd_int_ff) begin
               if (NW'(k_ff) + NW'(1) < n_eff) begin
                  prev_int_in = rd_int_ff;
                  prev_rc_in  = rd_rc_ff;
                  k_in        = k_ff + 1'b1;
                  state_in    = ST_READ;
               end else begin
                  color  = rd_rc_ff;
                  finish = 1'b1;
               end
            end else if (k_ff == '0) begin
               color  = rd_lc_ff;
               finish = 1'b1;
            end else begin
               b_in                = rd_lc_ff;
               div_req_in.start    = 1'b1;
               div_req_in.dividend = {v_ff - prev_int_ff, 16'b0};
               div_req_in.divisor  = rd_int_ff - prev_int_ff;
               state_in            = ST_DIV_F;
            end
         end
         ST_DIV_F: begin
            if (div_rsp.done) begin
               f_in     = div_rsp.quotient[16:0];
               ch_in    = '0;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            acc_in[8*ch_ff +: 8] = chan;
            ch_in = ch_ff + 2'd1;
            if (ch_ff == 2'd3) begin
               color  = {chan, acc_ff[23:0]};
               finish = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         rsp_valid_in           = 1'b1;
         rsp_item_in.entry_echo = x_in;
         rsp_item_in.red        = color[7:0];
         rsp_item_in.green      = color[15:8];
         rsp_item_in.blue       = color[23:16];
         rsp_item_in.alpha      = color[31:24];
         state_in               = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      v_ff        <= v_in;
      k_ff        <= k_in;
      prev_int_ff <= prev_int_in;
      prev_rc_ff  <= prev_rc_in;
      b_ff        <= b_in;
      f_ff        <= f_in;
      ch_ff       <= ch_in;
      acc_ff      <= acc_in;
      rsp_item_ff <= rsp_item_in;
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         div_req_ff.start <= div_req_in.start;
      end
   end

   assign div_req       = div_req_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_item_ff;
   assign status.active = (state_ff != ST_IDLE);
   assign status.pop    = pop;
endmodule
`default_nettype wire

>>> hdl/transfer_function_key_interpolator.sv
// top level of the transfer function key interpolator
// key write: stored when the back part pops it; out-of-band lookup: result registered on the pop
// in-band lookup: a divide for the position (none for a one-entry table), one store read per scanned
// key; between keys a fraction divide, then four channel mixes; both divides use the shared divider
// the back part handles one beat at a time; a two-entry queue lets start be taken meanwhile
// synchronous reset loads the register reset values and empties the queue; keys are not cleared
`default_nettype none
module transfer_function_key_interpolator
   import tfki_pkg::*;
#(
   parameter int MAX_KEYS    = 8,
   parameter int MAX_ENTRIES = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   csr_type          csr_ff, csr_in;
   front_status_type front_stat;
   back_status_type  back_stat;
   qentry_type       head;
   logic             head_valid;
   div_req_type      div_req;
   div_rsp_type      div_rsp;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (paddr[3:2])
            CSR_KEY_COUNT:       csr_in.key_count       = pwdata[3:0];
            CSR_TABLE_SIZE:      csr_in.table_size      = pwdata[12:0];
            CSR_LEFT_THRESHOLD:  csr_in.left_threshold  = pwdata[16:0];
            CSR_RIGHT_THRESHOLD: csr_in.right_threshold = pwdata[16:0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_KEY_COUNT:       prdata = {28'b0, csr_ff.key_count};
         CSR_TABLE_SIZE:      prdata = {19'b0, csr_ff.table_size};
         CSR_LEFT_THRESHOLD:  prdata = {15'b0, csr_ff.left_threshold};
         CSR_RIGHT_THRESHOLD: prdata = {15'b0, csr_ff.right_threshold};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.key_count       <= KEY_COUNT_RESET;
         csr_ff.table_size      <= TABLE_SIZE_RESET;
         csr_ff.left_threshold  <= LEFT_THRESHOLD_RESET;
         csr_ff.right_threshold <= RIGHT_THRESHOLD_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   tfki_front #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .item       (req_item),
      .csr        (csr_ff),
      .pop        (back_stat.pop),
      .busy       (busy),
      .head       (head),
      .head_valid (head_valid),
      .status     (front_stat)
   );

   tfki_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   tfki_back #(
      .MAX_KEYS    (MAX_KEYS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .head       (head),
      .head_valid (head_valid),
      .div_rsp    (div_rsp),
      .div_req    (div_req),
      .status     (back_stat),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

`include "transfer_function_key_interpolator_assert.svh"

   `TFKI_ASSERT_NEXT(a_accept_fills_stage, start && !busy, front_stat.stage_valid)
   `TFKI_ASSERT_SAME(a_queue_bound, 1'b1, front_stat.q_count <= 2'(Q_DEPTH))
   `TFKI_ASSERT_SAME(a_back_starts_from_queue, $rose(back_stat.active), $past(front_stat.q_count) != 2'd0)
   `TFKI_ASSERT_SAME(a_result_leaves_idle, rsp_valid, !back_stat.active)

endmodule
`default_nettype wire

>>> sim/tfki_checker.sv
// checker that predicts and compares interpolated colors for the key interpolator
`timescale 1ns / 1ps
`default_nettype none
module tfki_checker
   import tfki_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         busy,
   input  wire req_item_type req_item,
   input  wire logic         rsp_valid,
   input  wire rsp_item_type rsp_item,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [31:0]  pwdata,
   input  wire logic         pready,
   output int                mismatch_count,
   output int                colors_pending
);

   localparam int KEY_SLOTS  = 8;
   localparam int TABLE_MAX  = 4096;

   logic [16:0]  level_store [KEY_SLOTS];
   logic [31:0]  left_store  [KEY_SLOTS];
   logic [31:0]  right_store [KEY_SLOTS];
   csr_type      regs;
   rsp_item_type expected_colors [$];

   assign colors_pending = expected_colors.size();

   function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input logic [63:0] f);
      logic [31:0] res;
      logic [63:0] c;
      res = '0;
      for (int sh = 0; sh < 32; sh += 8) begin
         c = (64'(a[sh +: 8]) * (64'd65536 - f) + 64'(b[sh +: 8]) * f + 64'd32768) >> 16;
         res[sh +: 8] = c[7:0];
      end
      return res;
   endfunction

   function automatic rsp_item_type entry_color(input logic [11:0] x);
      rsp_item_type r;
      logic [63:0]  sz, front, back, v, li, ri, f;
      logic [31:0]  col;
      int           n, k;
      col = '0;
      sz = (regs.table_size > TABLE_MAX) ? 64'(TABLE_MAX) : 64'(regs.table_size);
      front = (64'(regs.left_threshold) * sz + 64'd32768) >> 16;
      back = (64'(regs.right_threshold) * sz + 64'd32768) >> 16;
      if (x >= front && x < back && x < sz) begin
         v = (sz > 1) ? (64'(x) << 16) / (sz - 1) : 64'd0;
         n = (regs.key_count == 0) ? 1 : int'(regs.key_count);
         if (n > KEY_SLOTS) n = KEY_SLOTS;
         k = 0;
         while (k < n && v > 64'(level_store[k])) k++;
         if (k == 0) begin
            col = left_store[0];
         end else if (k == n) begin
            col = right_store[n-1];
         end else begin
            li = 64'(level_store[k-1]);
            ri = 64'(level_store[k]);
            f = 0;
            if (ri > li && v > li) f = ((v - li) << 16) / (ri - li);
            if (f > 64'd65536) f = 64'd65536;
            col = blend(right_store[k-1], left_store[k], f);
         end
      end
      r.entry_echo = x;
      r.red = col[7:0];
      r.green = col[15:8];
      r.blue = col[23:16];
      r.alpha = col[31:24];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_item_type exp_c;
      if (reset) begin
         regs.key_count <= KEY_COUNT_RESET;
         regs.table_size <= TABLE_SIZE_RESET;
         regs.left_threshold <= LEFT_THRESHOLD_RESET;
         regs.right_threshold <= RIGHT_THRESHOLD_RESET;
         expected_colors.delete();
         mismatch_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_colors.size() == 0) begin
               $error("color beat with nothing expected: entry %0d", rsp_item.entry_echo);
               mismatch_count <= mismatch_count + 1;
            end else begin
               exp_c = expected_colors.pop_front();
               if (rsp_item !== exp_c) mismatch_count <= mismatch_count + 1;
               if (rsp_item.entry_echo !== exp_c.entry_echo)
                  $error("entry_echo expected %0d actual %0d", exp_c.entry_echo,
                         rsp_item.entry_echo);
               if (rsp_item.red !== exp_c.red)
                  $error("red expected %0d actual %0d", exp_c.red, rsp_item.red);
               if (rsp_item.green !== exp_c.green)
                  $error("green expected %0d actual %0d", exp_c.green, rsp_item.green);
               if (rsp_item.blue !== exp_c.blue)
                  $error("blue expected %0d actual %0d", exp_c.blue, rsp_item.blue);
               if (rsp_item.alpha !== exp_c.alpha)
                  $error("alpha expected %0d actual %0d", exp_c.alpha, rsp_item.alpha);
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               CSR_KEY_COUNT:       regs.key_count <= pwdata[3:0];
               CSR_TABLE_SIZE:      regs.table_size <= pwdata[12:0];
               CSR_LEFT_THRESHOLD:  regs.left_threshold <= pwdata[16:0];
               CSR_RIGHT_THRESHOLD: regs.right_threshold <= pwdata[16:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_item.mode == MODE_KEY) begin
               level_store[req_item.key_slot] <= req_item.key_level;
               left_store[req_item.key_slot] <= {req_item.left_alpha, req_item.left_blue,
                                                 req_item.left_green, req_item.left_red};
               right_store[req_item.key_slot] <= {req_item.right_alpha, req_item.right_blue,
                                                  req_item.right_green, req_item.right_red};
            end else begin
               expected_colors = {expected_colors, entry_color(req_item.entry_index)};
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> sim/tb_transfer_function_key_interpolator.sv
// stimulus and verdict for the transfer function key interpolator
`timescale 1ns / 1ps
`default_nettype none
module tb_transfer_function_key_interpolator;
   import tfki_pkg::*;

   localparam int REQ_W = $bits(req_item_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;
   int           mismatch_count;
   int           colors_pending;
   int           table_entries = 256;
   bit           no_gaps;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   transfer_function_key_interpolator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   tfki_checker color_check (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
      .mismatch_count(mismatch_count), .colors_pending(colors_pending)
   );

   task automatic send_beat(input req_item_type it);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (colors_pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_regs(input int kc, input int ts, input int lt, input int rt);
      csr_write(CSR_KEY_COUNT, 32'(kc));
      csr_write(CSR_TABLE_SIZE, 32'(ts));
      csr_write(CSR_LEFT_THRESHOLD, 32'(lt));
      csr_write(CSR_RIGHT_THRESHOLD, 32'(rt));
      table_entries = ts;
   endtask

   function automatic req_item_type key_beat(input int slot, input int lvl);
      req_item_type it;
      it = req_item_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
      it.mode = MODE_KEY;
      it.key_slot = 3'(slot);
      it.key_level = 17'(lvl);
      return it;
   endfunction

   function automatic req_item_type lookup_beat(input int x);
      req_item_type it;
      it = req_item_type'(REQ_W'({$urandom, $urandom, $urandom, $urandom}));
      it.mode = MODE_LOOKUP;
      it.entry_index = 12'(x);
      return it;
   endfunction

   function automatic int pick_entry();
      int lim;
      lim = (table_entries + 2 > 4095) ? 4095 : table_entries + 2;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 4095);
         1: return 0;
         2: return 4095;
         default: return $urandom_range(0, lim);
      endcase
   endfunction

   task automatic ascending_keys();
      int lv [8];
      int t;
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(0, 7))
            0: lv[i] = 0;
            1: lv[i] = 65536;
            default: lv[i] = $urandom_range(0, 65536);
         endcase
      end
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 7 - i; j++)
            if (lv[j] > lv[j+1]) begin
               t = lv[j];
               lv[j] = lv[j+1];
               lv[j+1] = t;
            end
      if ($urandom_range(0, 3) == 0) lv[3] = lv[2];
      for (int i = 0; i < 8; i++) send_beat(key_beat(i, lv[i]));
   endtask

   initial begin
      int kc_set [6] = '{8, 0, 15, 1, 8, 3};
      int ts_set [6] = '{256, 2, 4096, 1, 8191, 0};
      int lt_set [6] = '{0, 0, 16384, 0, 65536, 0};
      int rt_set [6] = '{65536, 131071, 49152, 65536, 65536, 65536};
      int kc, ts, lt, rt;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      no_gaps = 1'b0;
      // every slot written before any lookup
      for (int i = 0; i < 8; i++) send_beat(key_beat(i, i * 8192 + (i == 7 ? 8192 : 0)));
      send_beat(lookup_beat(0));
      send_beat(lookup_beat(255));
      send_beat(lookup_beat(256));
      send_beat(lookup_beat(4095));
      send_beat(lookup_beat(128));
      wait_idle();
      for (int p = 0; p < 10; p++) begin
         if (p < 6) begin
            kc = kc_set[p];
            ts = ts_set[p];
            lt = lt_set[p];
            rt = rt_set[p];
         end else begin
            kc = $urandom_range(0, 15);
            ts = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(2, 300);
            lt = $urandom_range(0, 32768);
            rt = ($urandom_range(0, 1) == 0) ? 65536 : $urandom_range(lt, 131071);
         end
         set_regs(kc, ts, lt, rt);
         no_gaps = (p % 3 == 1);
         if (p != 3) ascending_keys();
         for (int i = 0; i < 55; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(key_beat($urandom_range(0, 7), $urandom_range(0, 131071)));
            else
               send_beat(lookup_beat(pick_entry()));
            if (p == 7 && i == 20) begin
               start <= 1'b0;
               @(posedge clock);
               while (colors_pending != 0) @(posedge clock);
            end
         end
         wait_idle();
      end
      if (mismatch_count == 0 && colors_pending == 0) begin
         $display("transfer_function_key_interpolator test passed");
      end else begin
         $display("transfer_function_key_interpolator test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("transfer_function_key_interpolator test failed");
      $finish;
   end

endmodule
`default_nettype wire

>>> transfer_function_key_interpolator.f
+incdir+hdl
hdl/tfki_pkg.sv
hdl/tfki_front.sv
hdl/tfki_div.sv
hdl/tfki_back.sv
hdl/transfer_function_key_interpolator.sv
sim/tfki_checker.sv
sim/tb_transfer_function_key_interpolator.sv
